>>> rtl/ipv4dq_pkg.sv
// Shared types and constants for the IPv4 dotted-quad parser.
package ipv4dq_pkg;

   localparam int MAX_LENGTH_DEFAULT = 15;

   localparam int CH_W     = 8;
   localparam int STATUS_W = 3;
   localparam int ADDR_W   = 32;
   localparam int DIGIT_W  = 2;
   localparam int FIELD_W  = 10;
   localparam int DOT_W    = 3;

   localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
   localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE = 8'h39;
   localparam logic [CH_W-1:0] CH_DOT  = 8'h2E;

   localparam logic [FIELD_W-1:0] FIELD_MAX   = 10'd255;
   localparam logic [DIGIT_W-1:0] DIGITS_MAX  = 2'd3;
   localparam logic [DOT_W-1:0]   DOTS_NEEDED = 3'd3;
   localparam logic [DOT_W-1:0]   DOTS_SAT    = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_BAD    = 3'd1,
      ST_DIGITS = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_RANGE  = 3'd4,
      ST_DOTS   = 3'd5
   } status_type;

   typedef struct packed {
      logic              term;
      status_type        status;
      logic [ADDR_W-1:0] address;
   } parse_result_type;

endpackage

>>> rtl/ipv4dq_req_if.sv
// Request channel interface carrying one character per transaction.
interface ipv4dq_req_if;
   import ipv4dq_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

>>> rtl/ipv4dq_rsp_if.sv
// Response channel interface carrying a status and a parsed address.
interface ipv4dq_rsp_if;
   import ipv4dq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   address;

   modport source (output valid, output status, output address, input ready);
   modport sink   (input valid, input status, input address, output ready);
endinterface

>>> rtl/ipv4dq_parse.sv
// Parse state and per-character update logic of the dotted-quad parser.
module ipv4dq_parse #(
   parameter int MaxLength = ipv4dq_pkg::MAX_LENGTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [ipv4dq_pkg::CH_W-1:0]   ch,
   output ipv4dq_pkg::parse_result_type  result
);
   import ipv4dq_pkg::*;

   localparam int CntW = $clog2(MaxLength + 2);

   logic [CntW-1:0]    char_count_ff,  char_count_in;
   logic [DIGIT_W-1:0] digit_count_ff, digit_count_in;
   logic [FIELD_W-1:0] field_value_ff, field_value_in;
   logic [DOT_W-1:0]   dot_count_ff,   dot_count_in;
   status_type         first_error_ff, first_error_in;
   logic [ADDR_W-1:0]  address_acc_ff, address_acc_in;

   logic              is_term;
   logic              is_digit;
   logic              is_dot;
   logic              len_bad;
   status_type        close_err;
   status_type        final_err;
   status_type        status;
   logic [ADDR_W-1:0] shifted;

   assign is_term  = (ch == CH_NUL);
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_dot   = (ch == CH_DOT);

   assign shifted = {address_acc_ff[ADDR_W-9:0], field_value_ff[7:0]};

   always_comb begin
      if (digit_count_ff == '0) begin
         close_err = ST_EMPTY;
      end else if (field_value_ff > FIELD_MAX) begin
         close_err = ST_RANGE;
      end else begin
         close_err = ST_OK;
      end
   end

   assign final_err = (first_error_ff != ST_OK) ? first_error_ff : close_err;
   assign len_bad   = (char_count_ff == '0) || (char_count_ff > CntW'(MaxLength));

   always_comb begin
      if (len_bad) begin
         status = ST_BAD;
      end else if (final_err != ST_OK) begin
         status = final_err;
      end else if (dot_count_ff != DOTS_NEEDED) begin
         status = ST_DOTS;
      end else begin
         status = ST_OK;
      end
   end

   assign result.term    = is_term;
   assign result.status  = status;
   assign result.address = (status == ST_OK) ? shifted : '0;

   always_comb begin
      char_count_in  = char_count_ff;
      digit_count_in = digit_count_ff;
      field_value_in = field_value_ff;
      dot_count_in   = dot_count_ff;
      first_error_in = first_error_ff;
      address_acc_in = address_acc_ff;
      if (advance) begin
         if (is_term) begin
            char_count_in  = '0;
            digit_count_in = '0;
            field_value_in = '0;
            dot_count_in   = '0;
            first_error_in = ST_OK;
            address_acc_in = '0;
         end else begin
            if (char_count_ff <= CntW'(MaxLength)) begin
               char_count_in = char_count_ff + CntW'(1);
            end
            if (first_error_ff == ST_OK) begin
               if (is_digit) begin
                  if (digit_count_ff == DIGITS_MAX) begin
                     first_error_in = ST_DIGITS;
                  end else begin
                     field_value_in = {field_value_ff[FIELD_W-4:0], 3'b000}
                                    + {field_value_ff[FIELD_W-2:0], 1'b0}
                                    + FIELD_W'(ch[3:0]);
                     digit_count_in = digit_count_ff + DIGIT_W'(1);
                  end
               end else if (is_dot) begin
                  first_error_in = close_err;
                  digit_count_in = '0;
                  field_value_in = '0;
                  if (close_err == ST_OK) begin
                     address_acc_in = shifted;
                     if (dot_count_ff < DOTS_SAT) begin
                        dot_count_in = dot_count_ff + DOT_W'(1);
                     end
                  end
               end else begin
                  first_error_in = ST_BAD;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff  <= '0;
         digit_count_ff <= '0;
         field_value_ff <= '0;
         dot_count_ff   <= '0;
         first_error_ff <= ST_OK;
         address_acc_ff <= '0;
      end else begin
         char_count_ff  <= char_count_in;
         digit_count_ff <= digit_count_in;
         field_value_ff <= field_value_in;
         dot_count_ff   <= dot_count_in;
         first_error_ff <= first_error_in;
         address_acc_ff <= address_acc_in;
      end
   end

endmodule

>>> rtl/ipv4_dotted_quad_parser_core.sv
// IPv4 dotted-quad parser: the string arrives one ASCII character per
// transaction on the req_stream channel, and a zero character ends it.
// Each string ends in exactly one transaction on rsp_stream, carrying a
// status code and the address with its first octet in the top byte; the
// address is zero whenever the status is not ok. Characters other than
// the terminator give no response.
// A character is captured in an input register and then processed by the
// parse logic, which loads a terminator's response into the output
// register. One character is accepted every cycle, except while a
// terminator waits in the input register for the output register.
// When the receiver stalls, the response holds and one further character
// may wait in the input register; ordinary characters keep flowing, and
// only a second terminator waits for the output register to drain.
// A synchronous reset empties both registers and clears the parse state,
// discarding any string in progress. No clearing pass is needed.
module ipv4_dotted_quad_parser_core #(
   parameter int MaxLength = ipv4dq_pkg::MAX_LENGTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ipv4dq_req_if.sink    req_stream,
   ipv4dq_rsp_if.source  rsp_stream
);
   import ipv4dq_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CH_W-1:0]   in_ch_ff,    in_ch_in;
   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [ADDR_W-1:0] out_address_ff, out_address_in;

   parse_result_type  result;
   logic              out_free;
   logic              advance;
   logic              req_take;
   logic              load_out;

   ipv4dq_parse #(
      .MaxLength (MaxLength)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ch      (in_ch_ff),
      .result  (result)
   );

   assign out_free = !out_valid_ff || rsp_stream.ready;
   assign advance  = in_valid_ff && (!result.term || out_free);
   assign load_out = advance && result.term;

   assign req_stream.ready = !in_valid_ff || advance;
   assign req_take         = req_stream.valid && req_stream.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_ch_in    = req_stream.ch;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_address_in = out_address_ff;
      if (load_out) begin
         out_valid_in   = 1'b1;
         out_status_in  = result.status;
         out_address_in = result.address;
      end else if (rsp_stream.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff       <= in_ch_in;
      out_status_ff  <= out_status_in;
      out_address_ff <= out_address_in;
   end

   assign rsp_stream.valid   = out_valid_ff;
   assign rsp_stream.status  = out_status_ff;
   assign rsp_stream.address = out_address_ff;

endmodule

>>> rtl/ipv4dq_checker.sv
// Port-level assertions for the dotted-quad parser and their binding.
module ipv4dq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [ipv4dq_pkg::CH_W-1:0]       req_ch,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ipv4dq_pkg::STATUS_W-1:0]   rsp_status,
   input logic [ipv4dq_pkg::ADDR_W-1:0]     rsp_address
);
   import ipv4dq_pkg::*;

   // No response may survive a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A failed parse never reports an address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_address == '0))
      else $error("nonzero address with error status");

   // A new response must be preceded by an accepted terminator.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |->
         $past(req_valid && req_ready && (req_ch == CH_NUL), 2))
      else $error("response without a terminator");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_address)))
      else $error("stalled response changed");

endmodule

bind ipv4_dotted_quad_parser_core ipv4dq_checker u_ipv4dq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_stream.valid),
   .req_ready   (req_stream.ready),
   .req_ch      (req_stream.ch),
   .rsp_valid   (rsp_stream.valid),
   .rsp_ready   (rsp_stream.ready),
   .rsp_status  (rsp_stream.status),
   .rsp_address (rsp_stream.address)
);

>>> sim/ipv4_dotted_quad_parser_core_tb.sv
// Self-checking testbench for the IPv4 dotted-quad parser core.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_core_tb;
   import ipv4dq_pkg::*;

   localparam int MAX_LEN     = MAX_LENGTH_DEFAULT;
   localparam int CHAR_TARGET = 1050;
   localparam int QUIET_TAIL  = 150;
   localparam int STALL_LIMIT = 2000;

   typedef logic [CH_W-1:0] char_q_type[$];

   typedef struct {
      logic [CH_W-1:0] ch;
      bit              drain;
   } pending_char_type;

   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] address;
   } parse_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            drv_valid = 1'b0;
   logic [CH_W-1:0] drv_ch    = '0;
   logic            drv_ready = 1'b0;

   ipv4dq_req_if req_bus ();
   ipv4dq_rsp_if rsp_bus ();

   assign req_bus.valid = drv_valid;
   assign req_bus.ch    = drv_ch;
   assign rsp_bus.ready = drv_ready;

   ipv4_dotted_quad_parser_core #(
      .MaxLength(MAX_LEN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_stream(req_bus),
      .rsp_stream(rsp_bus)
   );

   pending_char_type  chars_to_send[$];
   parse_outcome_type expected_parses[$];

   logic [4:0]         char_count  = '0;
   logic [DIGIT_W-1:0] digit_count = '0;
   logic [FIELD_W-1:0] field_value = '0;
   logic [DOT_W-1:0]   dot_count   = '0;
   status_type         first_error = ST_OK;
   logic [ADDR_W-1:0]  address_acc = '0;

   int  mismatches  = 0;
   int  idle_cycles = 0;
   int  send_gap    = 0;
   int  stall_left  = 0;
   bit  req_taken   = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_parse_state();
      char_count  = '0;
      digit_count = '0;
      field_value = '0;
      dot_count   = '0;
      first_error = ST_OK;
      address_acc = '0;
   endfunction

   function automatic void close_field();
      if (digit_count == 0) begin
         first_error = ST_EMPTY;
      end else if (field_value > FIELD_MAX) begin
         first_error = ST_RANGE;
      end else begin
         address_acc = {address_acc[ADDR_W-9:0], field_value[7:0]};
      end
      digit_count = '0;
      field_value = '0;
   endfunction

   function automatic bit parse_char(input logic [CH_W-1:0] c, output parse_outcome_type res);
      bit is_digit;
      is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
      res.status  = ST_OK;
      res.address = '0;
      if (c == CH_NUL) begin
         if (first_error == ST_OK) close_field();
         if (char_count == 0 || char_count > MAX_LEN) begin
            res.status = ST_BAD;
         end else if (first_error != ST_OK) begin
            res.status = first_error;
         end else if (dot_count != DOTS_NEEDED) begin
            res.status = ST_DOTS;
         end else begin
            res.address = address_acc;
         end
         clear_parse_state();
         return 1'b1;
      end
      if (char_count <= MAX_LEN) char_count = char_count + 1'b1;
      if (first_error != ST_OK) return 1'b0;
      if (is_digit) begin
         if (digit_count == DIGITS_MAX) begin
            first_error = ST_DIGITS;
         end else begin
            field_value = FIELD_W'(field_value * 10 + (c - CH_ZERO));
            digit_count = digit_count + 1'b1;
         end
      end else if (c == CH_DOT) begin
         close_field();
         if (first_error == ST_OK && dot_count < DOTS_SAT) dot_count = dot_count + 1'b1;
      end else begin
         first_error = ST_BAD;
      end
      return 1'b0;
   endfunction

   task automatic add_bytes(input char_q_type s, input bit drain);
      pending_char_type item;
      foreach (s[i]) begin
         item.ch    = s[i];
         item.drain = drain && (i == 0);
         chars_to_send.push_back(item);
      end
      item.ch    = CH_NUL;
      item.drain = drain && (s.size() == 0);
      chars_to_send.push_back(item);
   endtask

   task automatic add_text(input string s);
      char_q_type q;
      q = {};
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      add_bytes(q, 1'b0);
   endtask

   task automatic make_random_string(output char_q_type s);
      int kind, fields, v, nd, p, pos;
      s    = {};
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         repeat ($urandom_range(0, 20)) begin
            case ($urandom_range(0, 3))
               0:       s.push_back(CH_W'(CH_ZERO + $urandom_range(0, 9)));
               1:       s.push_back(CH_DOT);
               default: s.push_back(CH_W'($urandom_range(1, 255)));
            endcase
         end
      end else begin
         fields = (kind < 25) ? $urandom_range(1, 6) : 4;
         for (int f = 0; f < fields; f++) begin
            if (f != 0) s.push_back(CH_DOT);
            v  = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
            nd = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
            if ($urandom_range(0, 5) == 0) nd = $urandom_range(nd, 4);
            if ($urandom_range(0, 19) == 0) nd = 0;
            for (int i = nd - 1; i >= 0; i--) begin
               p = 1;
               repeat (i) p = p * 10;
               s.push_back(CH_W'(CH_ZERO + (v / p) % 10));
            end
         end
         if (kind < 40) begin
            pos = $urandom_range(0, s.size());
            case ($urandom_range(0, 2))
               0: if (pos < s.size()) s[pos] = CH_W'($urandom_range(1, 255));
               1: s.insert(pos, ($urandom_range(0, 1) != 0) ? CH_DOT : CH_NINE);
               default: if (pos < s.size()) s.delete(pos);
            endcase
         end
      end
   endtask

   always @(negedge clock) begin
      pending_char_type next_item;
      if (reset) begin
         drv_valid <= 1'b0;
         send_gap  <= 0;
      end else if (drv_valid && !req_taken) begin
         drv_valid <= 1'b1;
      end else if (send_gap != 0) begin
         drv_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (chars_to_send.size() != 0 && chars_to_send[0].drain &&
                   expected_parses.size() != 0) begin
         drv_valid <= 1'b0;
      end else if (chars_to_send.size() > QUIET_TAIL && $urandom_range(0, 99) < 6) begin
         drv_valid <= 1'b0;
         send_gap  <= $urandom_range(0, 12);
      end else if (chars_to_send.size() != 0) begin
         next_item = chars_to_send.pop_front();
         drv_valid <= 1'b1;
         drv_ch    <= next_item.ch;
      end else begin
         drv_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         drv_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (chars_to_send.size() > QUIET_TAIL && $urandom_range(0, 99) < 8) begin
         drv_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 12);
      end else begin
         drv_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      parse_outcome_type predicted;
      parse_outcome_type want;
      bit req_fire, rsp_fire;
      if (reset) begin
         req_taken <= 1'b0;
         clear_parse_state();
      end else begin
         req_fire = req_bus.valid && req_bus.ready;
         rsp_fire = rsp_bus.valid && rsp_bus.ready;
         req_taken <= req_fire;
         if (req_fire && parse_char(req_bus.ch, predicted)) expected_parses.push_back(predicted);
         if (rsp_fire) begin
            if (expected_parses.size() == 0) begin
               $error("unexpected transaction: status %0d address 0x%08h",
                      rsp_bus.status, rsp_bus.address);
               mismatches++;
            end else begin
               want = expected_parses.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                  mismatches++;
               end
               if (rsp_bus.address !== want.address) begin
                  $error("address: expected 0x%08h, actual 0x%08h",
                         want.address, rsp_bus.address);
                  mismatches++;
               end
            end
         end
         if (req_fire || rsp_fire) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      char_q_type s;
      int strings_made;
      add_text("");
      add_text("255.0.0.9");
      add_text("1a");
      add_text("1234");
      add_text(".");
      add_text("256");
      add_text("1");
      strings_made = 0;
      while (chars_to_send.size() < CHAR_TARGET) begin
         make_random_string(s);
         add_bytes(s, (strings_made % 25) == 0);
         strings_made++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (chars_to_send.size() != 0 || drv_valid || expected_parses.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (expected_parses.size() != 0) begin
         $error("%0d expected transactions never arrived", expected_parses.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
